// File: rtl/flpr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes, the MAC control struct and the fixed
// predictor taps for the linear prediction restore block. No dependencies.
package flpr_pkg;

   localparam int MAX_ORDER       = 32;
   localparam int FIXED_MAX_ORDER = 4;
   localparam int ORDER_W         = $clog2(MAX_ORDER + 1);
   localparam int HIST_IDX_W      = $clog2(MAX_ORDER);
   localparam int SAMPLE_W        = 32;
   localparam int COEF_W          = 15;
   localparam int PROD_W          = SAMPLE_W + COEF_W;
   localparam int ACC_W           = 64;
   localparam int QSHIFT_W        = 4;
   localparam int WSHIFT_W        = 5;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_ORDER  = 2'd0;
   localparam logic [1:0] REG_KIND   = 2'd1;
   localparam logic [1:0] REG_QSHIFT = 2'd2;
   localparam logic [1:0] REG_WSHIFT = 2'd3;

   localparam logic REQ_COEF   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic KIND_FIXED = 1'b0;
   localparam logic KIND_LPC   = 1'b1;

   typedef struct packed {
      logic clear;
      logic op_valid;
   } mac_ctl_type;

   // standard fixed predictor taps; tap 0 applies to the newest sample
   function automatic logic signed [COEF_W-1:0] fixed_tap(input logic [2:0] ord,
                                                         input logic [1:0] idx);
      logic signed [COEF_W-1:0] t;
      begin
         t = '0;
         unique case (ord)
            3'd1: begin
               if (idx == 2'd0) t = COEF_W'(1);
            end
            3'd2: begin
               unique case (idx)
                  2'd0:    t = COEF_W'(2);
                  2'd1:    t = COEF_W'(-1);
                  default: t = '0;
               endcase
            end
            3'd3: begin
               unique case (idx)
                  2'd0:    t = COEF_W'(3);
                  2'd1:    t = COEF_W'(-3);
                  2'd2:    t = COEF_W'(1);
                  default: t = '0;
               endcase
            end
            3'd4: begin
               unique case (idx)
                  2'd0:    t = COEF_W'(4);
                  2'd1:    t = COEF_W'(-6);
                  2'd2:    t = COEF_W'(4);
                  default: t = COEF_W'(-1);
               endcase
            end
            default: t = '0;
         endcase
         return t;
      end
   endfunction

endpackage

// File: rtl/flpr_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one 32x15 signed product per cycle into
// a 64-bit accumulator. Depends on flpr_pkg.
module flpr_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  flpr_pkg::mac_ctl_type                ctl,
   input  logic signed [flpr_pkg::SAMPLE_W-1:0] hist_op,
   input  logic signed [flpr_pkg::COEF_W-1:0]   tap_op,
   output logic signed [flpr_pkg::ACC_W-1:0]    acc,
   output logic                                 busy
);

   logic signed [flpr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                               prod_vld_ff, prod_vld_in;
   logic signed [flpr_pkg::ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in     = hist_op * tap_op;
      prod_vld_in = ctl.op_valid && !ctl.clear;
      acc_in      = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + {{(flpr_pkg::ACC_W - flpr_pkg::PROD_W){prod_ff[flpr_pkg::PROD_W-1]}},
                            prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         acc_ff      <= acc_in;
      end
      prod_ff <= prod_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_vld_ff;

endmodule

// File: rtl/flac_linear_prediction_restore_unit.sv
`timescale 1ns / 1ps
// A coefficient load is taken while idle and gives no result. A warm-up sample, or
// any sample at order 0, goes through finish and emit to rsp; a predicted sample
// first issues its taps, one tap per cycle through the one shared MAC, then waits
// for the fetch and product registers to drain into the accumulator, then finish
// and output. A new request is taken only once the block is back in idle; a stalled
// result holds the block in emit until rsp takes it.
// Reset: synchronous; clears state, config, history and warm-up count, not coefficients.
module flac_linear_prediction_restore_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_type,
   input  logic [flpr_pkg::HIST_IDX_W-1:0]           req_coef_index,
   input  logic signed [flpr_pkg::COEF_W-1:0]        req_coef_value,
   input  logic signed [flpr_pkg::SAMPLE_W-1:0]      req_sample_value,
   input  logic                                      req_subframe_start,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [flpr_pkg::SAMPLE_W-1:0]      rsp_decoded_sample,
   output logic                                      rsp_is_warmup,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [flpr_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  logic [flpr_pkg::CSR_DATA_W-1:0]           csr_pwdata,
   output logic [flpr_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                      csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type                               state_ff, state_in;
   logic [flpr_pkg::ORDER_W-1:0]            cfg_order_ff, cfg_order_in;
   logic                                    cfg_kind_ff, cfg_kind_in;
   logic [flpr_pkg::QSHIFT_W-1:0]           cfg_qshift_ff, cfg_qshift_in;
   logic [flpr_pkg::WSHIFT_W-1:0]           cfg_wshift_ff, cfg_wshift_in;
   logic [flpr_pkg::ORDER_W-1:0]            order_ff, order_in;
   logic [flpr_pkg::ORDER_W-1:0]            warmup_cnt_ff, warmup_cnt_in;
   logic                                    warm_ff, warm_in;
   logic signed [flpr_pkg::SAMPLE_W-1:0]    resid_ff, resid_in;
   logic signed [flpr_pkg::SAMPLE_W-1:0]    sample_ff, sample_in;
   logic [flpr_pkg::HIST_IDX_W-1:0]         issue_idx_ff, issue_idx_in;
   logic                                    rd_vld_ff, rd_vld_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [flpr_pkg::SAMPLE_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                                    rsp_warm_ff, rsp_warm_in;

   logic signed [flpr_pkg::SAMPLE_W-1:0]    hist_ff [flpr_pkg::MAX_ORDER];
   logic signed [flpr_pkg::COEF_W-1:0]      coef_mem [flpr_pkg::MAX_ORDER];
   logic signed [flpr_pkg::SAMPLE_W-1:0]    hist_rd_ff;
   logic signed [flpr_pkg::COEF_W-1:0]      tap_rd_ff;

   logic                                    req_accept, cfg_write, sample_accept, coef_accept;
   logic [flpr_pkg::ORDER_W-1:0]            order_capped, order_active, wcnt_eff;
   logic                                    warm_now, last_issue, emit_load, push;
   logic signed [flpr_pkg::ACC_W-1:0]       mac_acc, acc_shifted;
   logic                                    mac_busy;
   logic [flpr_pkg::QSHIFT_W-1:0]           shift_amt;
   flpr_pkg::mac_ctl_type                   mac_ctl;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign sample_accept = req_accept && (req_type == flpr_pkg::REQ_SAMPLE);
   assign coef_accept   = req_accept && (req_type == flpr_pkg::REQ_COEF);
   assign cfg_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready    = 1'b1;

   always_comb begin
      unique case (csr_paddr[3:2])
         flpr_pkg::REG_ORDER:  csr_prdata = flpr_pkg::CSR_DATA_W'(cfg_order_ff);
         flpr_pkg::REG_KIND:   csr_prdata = flpr_pkg::CSR_DATA_W'(cfg_kind_ff);
         flpr_pkg::REG_QSHIFT: csr_prdata = flpr_pkg::CSR_DATA_W'(cfg_qshift_ff);
         default:              csr_prdata = flpr_pkg::CSR_DATA_W'(cfg_wshift_ff);
      endcase
   end

   // order in use: cap at the store depth, and at 4 for the fixed predictors
   always_comb begin
      order_capped = (cfg_order_ff > flpr_pkg::ORDER_W'(flpr_pkg::MAX_ORDER)) ?
                     flpr_pkg::ORDER_W'(flpr_pkg::MAX_ORDER) : cfg_order_ff;
      order_active = order_capped;
      if (cfg_kind_ff == flpr_pkg::KIND_FIXED &&
          order_capped > flpr_pkg::ORDER_W'(flpr_pkg::FIXED_MAX_ORDER)) begin
         order_active = flpr_pkg::ORDER_W'(flpr_pkg::FIXED_MAX_ORDER);
      end
      wcnt_eff = req_subframe_start ? '0 : warmup_cnt_ff;
      warm_now = wcnt_eff < order_active;
   end

   assign last_issue  = ({1'b0, issue_idx_ff} == (order_ff - flpr_pkg::ORDER_W'(1)));
   assign shift_amt   = (cfg_kind_ff == flpr_pkg::KIND_LPC) ? cfg_qshift_ff : '0;
   assign acc_shifted = mac_acc >>> shift_amt;
   assign emit_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign push        = (state_ff == ST_FINISH);

   always_comb begin
      state_in      = state_ff;
      cfg_order_in  = cfg_order_ff;
      cfg_kind_in   = cfg_kind_ff;
      cfg_qshift_in = cfg_qshift_ff;
      cfg_wshift_in = cfg_wshift_ff;
      order_in      = order_ff;
      warmup_cnt_in = warmup_cnt_ff;
      warm_in       = warm_ff;
      resid_in      = resid_ff;
      sample_in     = sample_ff;
      issue_idx_in  = issue_idx_ff;
      rd_vld_in     = (state_ff == ST_MAC);
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_warm_in   = rsp_warm_ff;
      mac_ctl.clear    = sample_accept;
      mac_ctl.op_valid = rd_vld_ff;

      if (cfg_write) begin
         unique case (csr_paddr[3:2])
            flpr_pkg::REG_ORDER:  cfg_order_in  = csr_pwdata[flpr_pkg::ORDER_W-1:0];
            flpr_pkg::REG_KIND:   cfg_kind_in   = csr_pwdata[0];
            flpr_pkg::REG_QSHIFT: cfg_qshift_in = csr_pwdata[flpr_pkg::QSHIFT_W-1:0];
            default:              cfg_wshift_in = csr_pwdata[flpr_pkg::WSHIFT_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (sample_accept) begin
               order_in      = order_active;
               warm_in       = warm_now;
               resid_in      = req_sample_value;
               issue_idx_in  = '0;
               warmup_cnt_in = warm_now ? (wcnt_eff + flpr_pkg::ORDER_W'(1)) : wcnt_eff;
               state_in      = (warm_now || order_active == '0) ? ST_FINISH : ST_MAC;
            end
         end
         ST_MAC: begin
            issue_idx_in = issue_idx_ff + flpr_pkg::HIST_IDX_W'(1);
            if (last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            sample_in = warm_ff ? resid_ff : (resid_ff + acc_shifted[flpr_pkg::SAMPLE_W-1:0]);
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff << cfg_wshift_ff;
               rsp_warm_in   = warm_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_order_ff  <= '0;
         cfg_kind_ff   <= flpr_pkg::KIND_FIXED;
         cfg_qshift_ff <= '0;
         cfg_wshift_ff <= '0;
         order_ff      <= '0;
         warmup_cnt_ff <= '0;
         warm_ff       <= 1'b0;
         issue_idx_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_order_ff  <= cfg_order_in;
         cfg_kind_ff   <= cfg_kind_in;
         cfg_qshift_ff <= cfg_qshift_in;
         cfg_wshift_ff <= cfg_wshift_in;
         order_ff      <= order_in;
         warmup_cnt_ff <= warmup_cnt_in;
         warm_ff       <= warm_in;
         issue_idx_ff  <= issue_idx_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      resid_ff      <= resid_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_warm_ff   <= rsp_warm_in;
   end

   // history shift line, entry 0 newest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < flpr_pkg::MAX_ORDER; i++) hist_ff[i] <= '0;
      end else if (push) begin
         hist_ff[0] <= sample_in;
         for (int i = 1; i < flpr_pkg::MAX_ORDER; i++) hist_ff[i] <= hist_ff[i-1];
      end
   end

   // coefficient store and registered operand fetch
   always_ff @(posedge clock) begin
      if (coef_accept) coef_mem[req_coef_index] <= req_coef_value;
      hist_rd_ff <= hist_ff[issue_idx_ff];
      tap_rd_ff  <= (cfg_kind_ff == flpr_pkg::KIND_LPC) ? coef_mem[issue_idx_ff] :
                    flpr_pkg::fixed_tap(order_ff[2:0], issue_idx_ff[1:0]);
   end

   flpr_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .hist_op (hist_rd_ff),
      .tap_op  (tap_rd_ff),
      .acc     (mac_acc),
      .busy    (mac_busy)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_sample = rsp_sample_ff;
   assign rsp_is_warmup      = rsp_warm_ff;

`ifndef SYNTHESIS
   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      order_ff <= flpr_pkg::ORDER_W'(flpr_pkg::MAX_ORDER))
      else $error("active order above store depth");

   a_warmup_bound: assert property (@(posedge clock) disable iff (reset)
      warmup_cnt_ff <= flpr_pkg::ORDER_W'(flpr_pkg::MAX_ORDER))
      else $error("warm-up count above store depth");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> ({1'b0, issue_idx_ff} < order_ff))
      else $error("tap issue beyond order");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!mac_busy && !rd_vld_ff))
      else $error("finish with MAC pipeline still busy");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (sample_accept && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result appeared one cycle after sample transaction");
`endif

endmodule

// File: sim/flpr_restore_checker.sv
`timescale 1ns / 1ps
// Response checker for flac_linear_prediction_restore_unit: follows register writes and
// accepted transactions, predicts each restored sample and compares it on rsp.
// Depends on flpr_pkg.
module flpr_restore_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [flpr_pkg::HIST_IDX_W-1:0]       req_coef_index,
   input  logic signed [flpr_pkg::COEF_W-1:0]    req_coef_value,
   input  logic signed [flpr_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                                  req_subframe_start,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [flpr_pkg::SAMPLE_W-1:0]  rsp_decoded_sample,
   input  logic                                  rsp_is_warmup,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [flpr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [flpr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   input  logic                                  csr_pready,
   output int                                    mismatches,
   output int                                    outstanding
);

   typedef struct packed {
      logic signed [flpr_pkg::SAMPLE_W-1:0] sample;
      logic                                 warm;
   } restored_type;

   restored_type restored_q[$];

   logic signed [flpr_pkg::SAMPLE_W-1:0] history [0:flpr_pkg::MAX_ORDER-1];
   logic signed [flpr_pkg::COEF_W-1:0]   taps [0:flpr_pkg::MAX_ORDER-1];
   logic [5:0]                           warm_cnt;
   logic [5:0]                           cfg_order;
   logic                                 cfg_kind;
   logic [flpr_pkg::QSHIFT_W-1:0]        cfg_qshift;
   logic [flpr_pkg::WSHIFT_W-1:0]        cfg_wshift;

   // fixed predictor of order n: tap j is (-1)^j * C(n, j+1)
   function automatic longint fixed_coef(input int ord, input int j);
      longint c;
      int     k;
      c = 1;
      for (k = 1; k <= j + 1; k++)
         c = c * (ord - k + 1) / k;
      return (j % 2 == 1) ? -c : c;
   endfunction

   function automatic longint prediction_sum(input int ord);
      longint acc;
      int     j;
      acc = 0;
      for (j = 0; j < ord; j++)
         acc += longint'(history[j]) * ((cfg_kind == flpr_pkg::KIND_LPC) ?
                                        longint'(taps[j]) : fixed_coef(ord, j));
      return (cfg_kind == flpr_pkg::KIND_LPC) ? (acc >>> cfg_qshift) : acc;
   endfunction

   always @(posedge clock) begin : watch
      int                                   eff_order;
      int                                   j;
      longint                               acc;
      logic signed [flpr_pkg::SAMPLE_W-1:0] value;
      logic                                 warm;
      restored_type                         got;
      restored_type                         want;
      if (reset) begin
         cfg_order  = '0;
         cfg_kind   = flpr_pkg::KIND_FIXED;
         cfg_qshift = '0;
         cfg_wshift = '0;
         warm_cnt   = '0;
         for (j = 0; j < flpr_pkg::MAX_ORDER; j++)
            history[j] = '0;
         restored_q.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               flpr_pkg::REG_ORDER:  cfg_order  = csr_pwdata[5:0];
               flpr_pkg::REG_KIND:   cfg_kind   = csr_pwdata[0];
               flpr_pkg::REG_QSHIFT: cfg_qshift = csr_pwdata[flpr_pkg::QSHIFT_W-1:0];
               flpr_pkg::REG_WSHIFT: cfg_wshift = csr_pwdata[flpr_pkg::WSHIFT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            got.sample = rsp_decoded_sample;
            got.warm   = rsp_is_warmup;
            if (restored_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected restored sample, actual %0d", $time, got.sample);
            end else begin
               want = restored_q.pop_front();
               if (got.sample !== want.sample) begin
                  mismatches++;
                  $display("%0t: decoded_sample expected %0d (0x%h) actual %0d (0x%h)",
                           $time, want.sample, want.sample, got.sample, got.sample);
               end
               if (got.warm !== want.warm) begin
                  mismatches++;
                  $display("%0t: is_warmup expected %0b actual %0b",
                           $time, want.warm, got.warm);
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (req_type == flpr_pkg::REQ_COEF) begin
               taps[req_coef_index] = req_coef_value;
            end else begin
               if (req_subframe_start)
                  warm_cnt = '0;
               eff_order = (cfg_order > flpr_pkg::MAX_ORDER) ? flpr_pkg::MAX_ORDER : cfg_order;
               if (cfg_kind == flpr_pkg::KIND_FIXED && eff_order > flpr_pkg::FIXED_MAX_ORDER)
                  eff_order = flpr_pkg::FIXED_MAX_ORDER;
               warm = (warm_cnt < eff_order);
               if (warm) begin
                  warm_cnt = warm_cnt + 6'd1;
                  value    = req_sample_value;
               end else begin
                  acc   = prediction_sum(eff_order);
                  value = req_sample_value + acc[31:0];
               end
               // newest restored sample goes to slot 0, before the wasted-bits shift
               for (j = flpr_pkg::MAX_ORDER - 1; j > 0; j--)
                  history[j] = history[j-1];
               history[0]  = value;
               want.sample = value << cfg_wshift;
               want.warm   = warm;
               restored_q.push_back(want);
            end
         end
      end
      outstanding = restored_q.size();
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the restore unit bench: clock, reset, register setup, directed and random
// transactions, random idling. Depends on flpr_pkg, the unit, flpr_restore_checker.
module testbench;

   localparam int ITEMS        = 850;
   localparam int IDLE_PCT     = 9;
   localparam int QUIET_FROM   = 450;
   localparam int QUIET_TO     = 600;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 48;
   localparam int TIMEOUT_NS   = 4000000;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_type;
   logic [flpr_pkg::HIST_IDX_W-1:0]       req_coef_index;
   logic signed [flpr_pkg::COEF_W-1:0]    req_coef_value;
   logic signed [flpr_pkg::SAMPLE_W-1:0]  req_sample_value;
   logic                                  req_subframe_start;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [flpr_pkg::SAMPLE_W-1:0]  rsp_decoded_sample;
   logic                                  rsp_is_warmup;
   logic                                  csr_psel;
   logic                                  csr_penable;
   logic                                  csr_pwrite;
   logic [flpr_pkg::CSR_ADDR_W-1:0]       csr_paddr;
   logic [flpr_pkg::CSR_DATA_W-1:0]       csr_pwdata;
   logic [flpr_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                  csr_pready;

   int mismatches;
   int pending;
   int n_sent    = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   flac_linear_prediction_restore_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_coef_index     (req_coef_index),
      .req_coef_value     (req_coef_value),
      .req_sample_value   (req_sample_value),
      .req_subframe_start (req_subframe_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded_sample (rsp_decoded_sample),
      .rsp_is_warmup      (rsp_is_warmup),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   flpr_restore_checker restore_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_coef_index     (req_coef_index),
      .req_coef_value     (req_coef_value),
      .req_sample_value   (req_sample_value),
      .req_subframe_start (req_subframe_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded_sample (rsp_decoded_sample),
      .rsp_is_warmup      (rsp_is_warmup),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatches         (mismatches),
      .outstanding        (pending)
   );

   function automatic bit quiet_stretch();
      return n_sent >= QUIET_FROM && n_sent < QUIET_TO;
   endfunction

   function automatic bit take_gap();
      return !quiet_stretch() && $urandom_range(99) < IDLE_PCT;
   endfunction

   // mostly 16-bit audio or small residuals, sometimes any 32-bit word
   function automatic logic signed [31:0] pick_sample(input bit residual);
      logic signed [15:0] pcm;
      logic signed [10:0] small_res;
      pcm       = 16'($urandom());
      small_res = 11'($urandom());
      if ($urandom_range(99) < 15)
         return $urandom();
      return residual ? 32'(small_res) : 32'(pcm);
   endfunction

   // receiver: random stalls, one long hold-off so the block backs up into req
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= take_gap();
      end
   end

   task automatic send_item(input logic kind, input logic [4:0] slot,
                            input logic signed [14:0] coef, input logic signed [31:0] value,
                            input logic first);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_coef_index     <= slot;
      req_coef_value     <= coef;
      req_sample_value   <= value;
      req_subframe_start <= first;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      n_sent++;
   endtask

   task automatic load_coef(input logic [4:0] slot, input logic signed [14:0] coef);
      send_item(flpr_pkg::REQ_COEF, slot, coef, $urandom(), 1'($urandom()));
   endtask

   task automatic send_sample(input logic signed [31:0] value, input logic first);
      send_item(flpr_pkg::REQ_SAMPLE, 5'($urandom()), 15'($urandom()), value, first);
   endtask

   // drop valid, wait for every restored sample, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup cycle then access cycle; psel stays up across back-to-back writes
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic configure(input logic [5:0] order, input logic kind,
                            input logic [3:0] qshift, input logic [4:0] wshift);
      settle();
      csr_write(flpr_pkg::REG_ORDER,  {26'($urandom()), order});
      csr_write(flpr_pkg::REG_KIND,   {31'($urandom()), kind});
      csr_write(flpr_pkg::REG_QSHIFT, {28'($urandom()), qshift});
      csr_write(flpr_pkg::REG_WSHIFT, {27'($urandom()), wshift});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      int         slot;
      int         k;
      int         len;
      int         active;
      int         pick;
      logic [5:0] order;
      logic       kind;
      logic [3:0] qshift;
      logic [4:0] wshift;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_type           <= flpr_pkg::REQ_COEF;
      req_coef_index     <= '0;
      req_coef_value     <= '0;
      req_sample_value   <= '0;
      req_subframe_start <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // write every tap before any LPC prediction can read one
      for (slot = 0; slot < flpr_pkg::MAX_ORDER; slot++)
         load_coef(5'(slot),
                   (slot == 0) ? 15'sh3FFF : (slot == 1) ? 15'sh4000 : 15'($urandom()));

      // fixed order 2, residuals that wrap the restored sample
      configure(2, flpr_pkg::KIND_FIXED, 0, 0);
      send_sample(32'sd100, 1'b1);
      send_sample(-32'sd200, 1'b0);
      send_sample(32'sh7FFFFFFF, 1'b0);
      send_sample(32'sh80000000, 1'b0);
      send_sample(32'sd0, 1'b0);

      // order above the fixed limit, raised mid-subframe: warm-up resumes up to four
      configure(7, flpr_pkg::KIND_FIXED, 15, 31);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sh7FFFFFFF, 1'b0);
      send_sample(32'sh80000000, 1'b0);
      send_sample(32'sd1, 1'b0);
      send_sample(-32'sd1, 1'b0);

      // LPC, coefficient extremes reloaded between samples, largest quantization shift
      configure(3, flpr_pkg::KIND_LPC, 15, 0);
      load_coef(0, 15'sh4000);
      load_coef(2, 15'sh3FFF);
      send_sample(32'sh7FFFFFFF, 1'b0);
      send_sample(-32'sd7, 1'b0);
      send_sample(32'sh80000000, 1'b1);
      send_sample(32'sh7FFFFFFF, 1'b0);
      send_sample(-32'sd32768, 1'b0);
      send_sample(32'sd12, 1'b0);

      // order 0: no warm-up, every sample passes with zero prediction
      configure(0, flpr_pkg::KIND_FIXED, 0, 5);
      send_sample(32'sh80000000, 1'b1);
      send_sample(32'sh7FFFFFFF, 1'b0);

      while (n_sent < ITEMS) begin
         kind = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (kind == flpr_pkg::KIND_LPC)
            order = (pick < 8)  ? 6'($urandom_range(63, 33)) :
                    (pick < 18) ? 6'd32 :
                    (pick < 60) ? 6'($urandom_range(8, 1)) : 6'($urandom_range(31));
         else
            order = (pick < 12) ? 6'($urandom_range(63, 5)) : 6'($urandom_range(4));
         qshift = 4'($urandom_range(15));
         wshift = ($urandom_range(99) < 60) ? 5'd0 : 5'($urandom_range(31));
         configure(order, kind, qshift, wshift);
         if (kind == flpr_pkg::KIND_LPC)
            active = (order > flpr_pkg::MAX_ORDER) ? flpr_pkg::MAX_ORDER : order;
         else
            active = (order > flpr_pkg::FIXED_MAX_ORDER) ? flpr_pkg::FIXED_MAX_ORDER : order;

         repeat ($urandom_range(3, 1)) begin
            // now and then carry on the previous subframe instead of restarting
            send_sample(pick_sample(1'b0), $urandom_range(9) != 0);
            len = active + $urandom_range(24, 3);
            for (k = 1; k < len; k++) begin
               pick = $urandom_range(99);
               if (pick < 8)
                  load_coef(5'($urandom()), 15'($urandom()));
               else
                  send_sample(pick_sample(k >= active), pick < 11);
            end
         end
      end

      settle();
      if (mismatches == 0 && pending == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("testbench failed");
      $finish;
   end

endmodule

// File: files.f
rtl/flpr_pkg.sv
rtl/flpr_mac.sv
rtl/flac_linear_prediction_restore_unit.sv
sim/flpr_restore_checker.sv
sim/testbench.sv
